// File: hw/rtl/fbpa_pkg.sv
`timescale 1ns / 1ps

package fbpa_pkg;

  // Widths fixed by the register and field definitions.
  localparam int SLOT_COUNT_W = 11;
  localparam int ITEM_BYTES_W = 17;
  localparam int OFFSET_W     = 32;
  localparam int STATUS_W     = 2;
  localparam int BUMP_W       = 11;

  // Slot stride covers a rounded item of up to 2^17 bytes plus a link of up to 16 bytes.
  localparam int STRIDE_W    = 18;
  localparam int ALIGN_BYTES = 8;

  // One quotient bit per divider step.
  localparam int DIV_STEPS = OFFSET_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam logic REG_SLOT_COUNT = 1'b0;
  localparam logic REG_ITEM_BYTES = 1'b1;

  // Request codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_ALLOC     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FREED     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED  = 2'd3;

  typedef struct packed {
    logic                opcode;
    logic [OFFSET_W-1:0] content_offset;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] granted_offset;
  } result_t;

  typedef struct packed {
    logic [SLOT_COUNT_W-1:0] slot_count;
    logic [ITEM_BYTES_W-1:0] item_bytes;
  } cfg_t;

  typedef struct packed {
    logic                done;
    logic                rem_zero;
    logic [OFFSET_W-1:0] quotient;
  } div_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_WAIT,
    ST_MUL,
    ST_ADD,
    ST_DIV
  } state_t;

endpackage

// File: hw/rtl/fbpa_cfg_regs.sv
`timescale 1ns / 1ps

module fbpa_cfg_regs import fbpa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Registers sit on word addresses; the byte lane bits are not decoded.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_count <= SLOT_COUNT_W'(1024);
      cfg.item_bytes <= ITEM_BYTES_W'(64);
    end else if (wr_en) begin
      case (paddr[2])
        REG_SLOT_COUNT: cfg.slot_count <= pwdata[SLOT_COUNT_W-1:0];
        REG_ITEM_BYTES: cfg.item_bytes <= pwdata[ITEM_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SLOT_COUNT: prdata = 32'(cfg.slot_count);
      REG_ITEM_BYTES: prdata = 32'(cfg.item_bytes);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/fbpa_link_mem.sv
`timescale 1ns / 1ps

module fbpa_link_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/fbpa_divider.sv
`timescale 1ns / 1ps

module fbpa_divider import fbpa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [OFFSET_W-1:0] dividend,
  input  logic [STRIDE_W-1:0] divisor,
  output div_result_t         res
);

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

  logic                 active;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [OFFSET_W-1:0]  dvd;
  logic [STRIDE_W-1:0]  rem;
  logic [STRIDE_W-1:0]  dvs;
  logic [STRIDE_W:0]    trial;
  logic                 q_bit;
  logic [STRIDE_W-1:0]  rem_next;

  // Restoring division: one quotient bit shifts into the dividend register per step.
  always_comb begin
    trial = {rem, dvd[OFFSET_W-1]};
    q_bit = (trial >= {1'b0, dvs});
    if (q_bit) begin
      rem_next = STRIDE_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[STRIDE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (active) begin
      dvd <= {dvd[OFFSET_W-2:0], q_bit};
      rem <= rem_next;
    end
  end

  assign res.done     = done;
  assign res.rem_zero = (rem == '0);
  assign res.quotient = dvd;

endmodule

// File: hw/rtl/fixed_block_pool_allocator_core.sv
`timescale 1ns / 1ps
// Allocate: ST_MUL then ST_ADD when bumping; ST_POP_WAIT first when popping the list.
// Free: ST_DIV waits on the 32-step shift-subtract divider, then reports the result.
// Rejects inside the header and exhausted allocations report in the cycle after accept.
// One transaction at a time; the next is accepted in the cycle its predecessor reports.
// Synchronous active-high reset empties the free list and the bump counter and
// restores the configuration defaults; the link memory needs no clearing pass.
module fixed_block_pool_allocator_core import fbpa_pkg::*; #(
  parameter int MAX_SLOTS    = 1024,
  parameter int HEADER_BYTES = 40,
  parameter int LINK_BYTES   = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Command channel: a transaction is taken when start is high and busy is low.
  input  logic        start,
  input  cmd_t        cmd,
  output logic        busy,
  // Result channel: done marks a one-cycle result that cannot be stalled.
  output logic        done,
  output result_t     result,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Slot indexes address the link memory; a slot times the stride is the product width.
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int PROD_W = SLOT_W + STRIDE_W;
  localparam int LINK_W = SLOT_W + 1;

  // First content byte of slot zero; free offsets below it are rejected outright.
  localparam logic [OFFSET_W-1:0] CONTENT_BASE = OFFSET_W'(HEADER_BYTES + LINK_BYTES);
  localparam logic [STRIDE_W-1:0] ALIGN_MASK   = STRIDE_W'(ALIGN_BYTES - 1);

  cfg_t        cfg;
  div_result_t div_res;

  state_t state;
  state_t state_next;

  // Free-list and bump state. The list top lives in registers; the links of the
  // slots below it live in the link memory, each tagged with a valid bit that
  // says whether another slot follows.
  logic [SLOT_W-1:0] head;
  logic              nonempty;
  logic [BUMP_W-1:0] bump;

  logic [SLOT_W-1:0] slot;
  logic [PROD_W-1:0] prod;

  logic [STRIDE_W-1:0]     stride;
  logic [SLOT_COUNT_W-1:0] eff_count;
  logic                    accept;
  logic                    div_start;
  logic [OFFSET_W-1:0]     rel_offset;
  logic                    free_ok;
  logic [SLOT_W-1:0]       free_slot;
  logic                    link_we;
  logic [LINK_W-1:0]       link_rdata;

  fbpa_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stride is the link plus the item size rounded up to a multiple of eight bytes.
  assign stride = ((STRIDE_W'(cfg.item_bytes) + ALIGN_MASK) & ~ALIGN_MASK)
                  + STRIDE_W'(LINK_BYTES);

  // A slot count above the memory depth acts as the memory depth.
  assign eff_count = (32'(cfg.slot_count) > MAX_SLOTS) ? SLOT_COUNT_W'(MAX_SLOTS)
                                                       : cfg.slot_count;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign rel_offset = cmd.content_offset - CONTENT_BASE;
  assign div_start  = accept && (cmd.opcode == OP_FREE) && (cmd.content_offset >= CONTENT_BASE);

  fbpa_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rel_offset),
    .divisor  (stride),
    .res      (div_res)
  );

  // A freed offset is good when it sits on a slot boundary and names a slot in the pool.
  assign free_ok   = div_res.rem_zero && (div_res.quotient < OFFSET_W'(eff_count));
  assign free_slot = SLOT_W'(div_res.quotient);
  assign link_we   = (state == ST_DIV) && div_res.done && free_ok;

  // The memory is always read at the list top. A pop issues its read in the accept
  // cycle and uses the data in the next cycle; a push writes at the end of a free, so a
  // later pop never reads an entry in the cycle it is written.
  fbpa_link_mem #(
    .DEPTH  (MAX_SLOTS),
    .DATA_W (LINK_W)
  ) u_link_mem (
    .clk   (clk),
    .we    (link_we),
    .waddr (free_slot),
    .wdata ({nonempty, head}),
    .raddr (head),
    .rdata (link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd.opcode == OP_ALLOC) begin
            if (nonempty) begin
              state_next = ST_POP_WAIT;
            end else if (bump < BUMP_W'(eff_count)) begin
              state_next = ST_MUL;
            end
          end else if (div_start) begin
            state_next = ST_DIV;
          end
        end
      end
      ST_POP_WAIT: state_next = ST_MUL;
      ST_MUL:      state_next = ST_ADD;
      ST_ADD:      state_next = ST_IDLE;
      ST_DIV: begin
        if (div_res.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // List and counter updates, and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      nonempty <= 1'b0;
      bump     <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cmd.opcode == OP_ALLOC) begin
              if (!nonempty && (bump < BUMP_W'(eff_count))) begin
                bump <= bump + 1'b1;
              end else if (!nonempty) begin
                done <= 1'b1;
              end
            end else if (!div_start) begin
              done <= 1'b1;
            end
          end
        end
        ST_POP_WAIT: begin
          head     <= link_rdata[SLOT_W-1:0];
          nonempty <= link_rdata[SLOT_W];
        end
        ST_ADD: done <= 1'b1;
        ST_DIV: begin
          if (div_res.done) begin
            done <= 1'b1;
            if (free_ok) begin
              head     <= free_slot;
              nonempty <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath: slot capture, the registered product, and the result fields.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          result.granted_offset <= '0;
          if (cmd.opcode == OP_ALLOC) begin
            if (nonempty) begin
              slot <= head;
            end else begin
              slot <= SLOT_W'(bump);
            end
            result.status <= STATUS_EXHAUSTED;
          end else begin
            result.status <= STATUS_REJECTED;
          end
        end
      end
      ST_MUL: prod <= PROD_W'(slot) * PROD_W'(stride);
      ST_ADD: begin
        result.status         <= STATUS_ALLOC;
        result.granted_offset <= CONTENT_BASE + OFFSET_W'(prod);
      end
      ST_DIV: begin
        if (div_res.done) begin
          result.status         <= free_ok ? STATUS_FREED : STATUS_REJECTED;
          result.granted_offset <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule
